// ===== rtl/multiturn_encoder_zero_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-turn encoder zero tracker
// Shared concurrent-check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTITURN_ENCODER_ZERO_TRACKER_CORE_DEFINES_SVH
`define MULTITURN_ENCODER_ZERO_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication
`define MEZT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication
`define MEZT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/mezt_pkg.sv =====
// ----------------------------------------------------------------------------
// mezt_pkg
// Types and constants shared by the encoder zero tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mezt_pkg;

  // Default wrap detection and turn scaling
  localparam int unsigned WRAP_THRESHOLD_DEF  = 4096;
  localparam int unsigned COUNTS_PER_TURN_DEF = 8191;

  // Configuration register map
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CALIBRATED  = 4'd0,
    REG_TORQUE_GAIN = 4'd1
  } reg_index_t;

  // Saturation limits
  localparam logic signed [31:0] TURN_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TURN_MIN  = 32'sh8000_0000;
  localparam logic signed [47:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] TOTAL_MIN = 48'sh8000_0000_0000;

  // Unpacked frame plus updated turn count
  typedef struct packed {
    logic        [15:0] angle;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] current_lsb;
    logic        [7:0]  temperature;
    logic signed [31:0] turns;
  } frame_t;

  // Frame with raw multi-turn count and torque
  typedef struct packed {
    frame_t             frame;
    logic signed [47:0] raw;
    logic signed [47:0] torque;
  } scaled_t;

  // Complete result item
  typedef struct packed {
    frame_t             frame;
    logic signed [47:0] total_counts;
    logic signed [47:0] prev_total_counts;
    logic signed [47:0] torque_q16;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/mezt_turn.sv =====
// ----------------------------------------------------------------------------
// mezt_turn
// Frame unpack and wrap detection; keeps last angle and saturating turn count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiturn_encoder_zero_tracker_core_defines.svh"

module mezt_turn
  import mezt_pkg::*;
#(
  parameter int unsigned WRAP_THRESHOLD = WRAP_THRESHOLD_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] pos_high,
  input  wire logic [7:0] pos_low,
  input  wire logic [7:0] vel_high,
  input  wire logic [7:0] vel_low,
  input  wire logic [7:0] cur_high,
  input  wire logic [7:0] cur_low,
  input  wire logic [7:0] temp_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output frame_t          out_frame
);

  localparam logic signed [16:0] WRAP_LIM = 17'(WRAP_THRESHOLD);

  logic               [15:0] last_angle;
  logic signed        [31:0] turn_count;
  logic signed        [31:0] turn_count_next;
  logic               [15:0] pos;
  logic signed        [16:0] diff;
  logic                      wrap_fwd;
  logic                      wrap_back;
  logic                      acc;
  logic                      load;

  // Handshake: stage register refills when empty or being drained
  assign load     = !out_valid || out_ready;
  assign in_stall = !load;
  assign acc      = in_valid && load;

  // Wrap detection against previous position
  assign pos       = {pos_high, pos_low};
  assign diff      = $signed({1'b0, last_angle}) - $signed({1'b0, pos});
  assign wrap_fwd  = diff > WRAP_LIM;
  assign wrap_back = diff < -WRAP_LIM;

  // Saturating turn counter
  always_comb begin
    turn_count_next = turn_count;
    if (wrap_fwd && (turn_count != TURN_MAX)) begin
      turn_count_next = turn_count + 32'sd1;
    end else if (wrap_back && (turn_count != TURN_MIN)) begin
      turn_count_next = turn_count - 32'sd1;
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle <= '0;
      turn_count <= '0;
    end else if (acc) begin
      last_angle <= pos;
      turn_count <= turn_count_next;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_frame.angle       <= pos;
      out_frame.speed_rpm   <= $signed({vel_high, vel_low});
      out_frame.current_lsb <= $signed({cur_high, cur_low});
      out_frame.temperature <= temp_byte;
      out_frame.turns       <= turn_count_next;
    end
  end

  // Checks
  `MEZT_ASSERT_NEXT(a_turn_hold_idle, !rst && !acc, turn_count == $past(turn_count))
  `MEZT_ASSERT_NEXT(a_turn_hold_nowrap, !rst && acc && !wrap_fwd && !wrap_back,
                    turn_count == $past(turn_count))
  `MEZT_ASSERT_NEXT(a_angle_follows, !rst && acc, last_angle == $past(pos))

endmodule

`default_nettype wire

// ===== rtl/mezt_scale.sv =====
// ----------------------------------------------------------------------------
// mezt_scale
// Two stages: turn and torque multiplies, then saturated raw multi-turn count.
// ----------------------------------------------------------------------------
`default_nettype none

module mezt_scale
  import mezt_pkg::*;
#(
  parameter int unsigned COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] torque_gain,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire frame_t      in_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output scaled_t          out_data
);

  localparam int unsigned CPT_W  = $clog2(COUNTS_PER_TURN + 1);
  localparam int unsigned PROD_W = 32 + CPT_W + 1;
  localparam int unsigned SUM_W  = (PROD_W + 1 > 49) ? PROD_W + 1 : 49;
  localparam logic [CPT_W-1:0] CPT = CPT_W'(COUNTS_PER_TURN);

  logic                     mul_valid;
  logic                     mul_ready;
  frame_t                   mul_frame;
  logic signed [PROD_W-1:0] mul_prod;
  logic signed [47:0]       mul_torque;
  logic                     out_load;
  logic signed [SUM_W-1:0]  sum;
  logic signed [47:0]       raw_sat;

  assign out_load  = !out_valid || out_ready;
  assign mul_ready = !mul_valid || out_load;
  assign in_ready  = mul_ready;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && in_valid) begin
      mul_frame  <= in_frame;
      mul_prod   <= PROD_W'(in_frame.turns) * PROD_W'($signed({1'b0, CPT}));
      mul_torque <= 48'(in_frame.current_lsb) * 48'($signed({1'b0, torque_gain}));
    end
  end

  // Raw count: turns*cpt + position, saturated to 48 bits
  assign sum = SUM_W'(mul_prod) + $signed({{(SUM_W-16){1'b0}}, mul_frame.angle});

  always_comb begin
    if (sum > SUM_W'(TOTAL_MAX)) begin
      raw_sat = TOTAL_MAX;
    end else if (sum < SUM_W'(TOTAL_MIN)) begin
      raw_sat = TOTAL_MIN;
    end else begin
      raw_sat = sum[47:0];
    end
  end

  // Raw count stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && mul_valid) begin
      out_data.frame  <= mul_frame;
      out_data.raw    <= raw_sat;
      out_data.torque <= mul_torque;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mezt_offset.sv =====
// ----------------------------------------------------------------------------
// mezt_offset
// Zero offset tracking, total and previous total, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiturn_encoder_zero_tracker_core_defines.svh"

module mezt_offset
  import mezt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    calibrated,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire scaled_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic signed [47:0] zero_offset;
  logic signed [47:0] last_total;
  logic signed [48:0] diff;
  logic signed [47:0] total;
  logic               take;

  assign in_ready = !out_valid || !out_stall;
  assign take     = in_valid && in_ready;

  // Total relative to zero, saturated
  assign diff = $signed({in_data.raw[47], in_data.raw}) -
                $signed({zero_offset[47], zero_offset});

  always_comb begin
    if (diff > 49'(TOTAL_MAX)) begin
      total = TOTAL_MAX;
    end else if (diff < 49'(TOTAL_MIN)) begin
      total = TOTAL_MIN;
    end else begin
      total = diff[47:0];
    end
  end

  // Offset and history state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= '0;
      last_total  <= '0;
    end else if (take) begin
      last_total <= total;
      if (!calibrated) begin
        zero_offset <= in_data.raw;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.frame             <= in_data.frame;
      out_data.total_counts      <= total;
      out_data.prev_total_counts <= last_total;
      out_data.torque_q16        <= in_data.torque;
    end
  end

  // Checks
  `MEZT_ASSERT_NEXT(a_zero_held_cal, !rst && calibrated, zero_offset == $past(zero_offset))
  `MEZT_ASSERT_NEXT(a_hist_hold_idle, !rst && !take, last_total == $past(last_total))
  `MEZT_ASSERT_NEXT(a_prev_is_last, !rst && take,
                    out_data.prev_total_counts == $past(last_total))

endmodule

`default_nettype wire

// ===== rtl/multiturn_encoder_zero_tracker_core.sv =====
// Path: a transferred frame loads the turn stage, then passes the multiply,
//   raw count and result stages; it transfers out of the result register
//   while out_stall is low.
// Throughput: one frame per cycle unless out_stall holds the pipeline.
// Reset (rst, synchronous): turn count, last angle, zero offset, last total and
//   both configuration registers clear to zero; all stages empty.
// ----------------------------------------------------------------------------
// multiturn_encoder_zero_tracker_core
// Motor feedback frame unpack, multi-turn counting, zero offset and torque.
// ----------------------------------------------------------------------------
`default_nettype none

module multiturn_encoder_zero_tracker_core
  import mezt_pkg::*;
#(
  parameter int unsigned WRAP_THRESHOLD  = WRAP_THRESHOLD_DEF,
  parameter int unsigned COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // frame input
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             pos_high,
  input  wire logic [7:0]             pos_low,
  input  wire logic [7:0]             vel_high,
  input  wire logic [7:0]             vel_low,
  input  wire logic [7:0]             cur_high,
  input  wire logic [7:0]             cur_low,
  input  wire logic [7:0]             temp_byte,
  // result output
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [15:0]                 angle,
  output logic signed [15:0]          speed_rpm,
  output logic signed [15:0]          current_lsb,
  output logic [7:0]                  temperature,
  output logic signed [31:0]          turns,
  output logic signed [47:0]          total_counts,
  output logic signed [47:0]          prev_total_counts,
  output logic signed [47:0]          torque_q16
);

  logic        calibrated;
  logic [31:0] torque_gain;

  logic    turn_valid;
  logic    turn_ready;
  frame_t  turn_frame;
  logic    scale_valid;
  logic    scale_ready;
  scaled_t scale_data;
  result_t result;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated  <= 1'b0;
      torque_gain <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CALIBRATED:  calibrated  <= cfg_data[0];
        REG_TORQUE_GAIN: torque_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Turn tracking stage
  mezt_turn #(
    .WRAP_THRESHOLD (WRAP_THRESHOLD)
  ) u_turn (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_high  (pos_high),
    .pos_low   (pos_low),
    .vel_high  (vel_high),
    .vel_low   (vel_low),
    .cur_high  (cur_high),
    .cur_low   (cur_low),
    .temp_byte (temp_byte),
    .out_valid (turn_valid),
    .out_ready (turn_ready),
    .out_frame (turn_frame)
  );

  // Multiply and raw count stages
  mezt_scale #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .torque_gain (torque_gain),
    .in_valid    (turn_valid),
    .in_ready    (turn_ready),
    .in_frame    (turn_frame),
    .out_valid   (scale_valid),
    .out_ready   (scale_ready),
    .out_data    (scale_data)
  );

  // Zero offset and result register
  mezt_offset u_offset (
    .clk        (clk),
    .rst        (rst),
    .calibrated (calibrated),
    .in_valid   (scale_valid),
    .in_ready   (scale_ready),
    .in_data    (scale_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (result)
  );

  // Result fields
  assign angle             = result.frame.angle;
  assign speed_rpm         = result.frame.speed_rpm;
  assign current_lsb       = result.frame.current_lsb;
  assign temperature       = result.frame.temperature;
  assign turns             = result.frame.turns;
  assign total_counts      = result.total_counts;
  assign prev_total_counts = result.prev_total_counts;
  assign torque_q16        = result.torque_q16;

endmodule

`default_nettype wire

// ===== verif/multiturn_encoder_zero_tracker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiturn_encoder_zero_tracker_core_tb
// Self-checking bench for the encoder zero tracker. Feedback frames are
// driven with random gaps and random output back-pressure. A behavioural
// turn counter predicts each result, and every result transfer is compared
// field by field. A directed table comes first: reset values, byte extremes,
// the wrap threshold on both sides, calibration on and off, torque gain
// extremes and ignored register writes. Random phases follow, each with its
// own register settings and motion profile.
// ----------------------------------------------------------------------------
module multiturn_encoder_zero_tracker_core_tb;
  import mezt_pkg::*;

  localparam int     WRAP      = int'(WRAP_THRESHOLD_DEF);
  localparam longint TURN_SPAN = longint'(COUNTS_PER_TURN_DEF);

  // register indexes that decode to nothing
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = CFG_INDEX_W'(REG_TORQUE_GAIN + 1);
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = '1;

  localparam logic [31:0] GAIN_UNITY = 32'h0001_0000;
  localparam logic [31:0] GAIN_MAX   = 32'hFFFF_FFFF;

  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 117;
  localparam int STEADY_PHS = 3;

  // one feedback frame, byte 0 in the top bits
  typedef struct packed {
    logic [7:0] pos_high;
    logic [7:0] pos_low;
    logic [7:0] vel_high;
    logic [7:0] vel_low;
    logic [7:0] cur_high;
    logic [7:0] cur_low;
    logic [7:0] temp_byte;
  } feedback_frame_t;

  // directed table row: a register write or a frame
  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [31:0]            val;
    feedback_frame_t        frame;
    bit                     typed;
    result_t                want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] pos_high  = '0;
  logic [7:0] pos_low   = '0;
  logic [7:0] vel_high  = '0;
  logic [7:0] vel_low   = '0;
  logic [7:0] cur_high  = '0;
  logic [7:0] cur_low   = '0;
  logic [7:0] temp_byte = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [15:0] angle;
  logic signed [15:0] speed_rpm;
  logic signed [15:0] current_lsb;
  logic        [7:0]  temperature;
  logic signed [31:0] turns;
  logic signed [47:0] total_counts;
  logic signed [47:0] prev_total_counts;
  logic signed [47:0] torque_q16;

  // predicted tracker state and registers
  logic        [15:0] seen_angle  = '0;
  logic signed [31:0] turn_tally  = '0;
  longint             zero_ref    = 0;
  longint             prior_total = 0;
  logic               calib_on    = 1'b0;
  logic        [31:0] gain_q16    = '0;

  result_t   awaited_results[$];
  result_t   head_result;
  int        mismatches = 0;
  bit        steady     = 1'b0;
  step_row_t directed[$];

  multiturn_encoder_zero_tracker_core DUT (.*);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // clamp to the signed 48-bit range
  function automatic longint clamp48(longint v);
    if (v > longint'(TOTAL_MAX)) return longint'(TOTAL_MAX);
    if (v < longint'(TOTAL_MIN)) return longint'(TOTAL_MIN);
    return v;
  endfunction

  // advance the turn counter and zero offset by one frame, return its result
  function automatic result_t track_frame(feedback_frame_t f);
    result_t     r;
    logic [15:0] pos;
    int          diff;
    longint      raw;
    longint      total;
    pos  = {f.pos_high, f.pos_low};
    diff = int'(seen_angle) - int'(pos);
    if (diff > WRAP) begin
      if (turn_tally != TURN_MAX) turn_tally++;
    end else if (diff < -WRAP) begin
      if (turn_tally != TURN_MIN) turn_tally--;
    end
    seen_angle = pos;
    raw   = clamp48(longint'(turn_tally) * TURN_SPAN + longint'(pos));
    total = clamp48(raw - zero_ref);
    r.prev_total_counts = prior_total[47:0];
    prior_total = total;
    // uncalibrated: the zero follows the raw multi-turn count
    if (!calib_on) zero_ref = raw;
    r.frame.angle       = pos;
    r.frame.speed_rpm   = {f.vel_high, f.vel_low};
    r.frame.current_lsb = {f.cur_high, f.cur_low};
    r.frame.temperature = f.temp_byte;
    r.frame.turns       = turn_tally;
    r.total_counts      = total[47:0];
    r.torque_q16        = 48'(longint'($signed({f.cur_high, f.cur_low}))
                              * longint'(gain_q16));
    return r;
  endfunction

  function automatic step_row_t frame_row(feedback_frame_t f, bit typed = 1'b0,
                                          result_t want = '0);
    step_row_t s;
    s.is_cfg = 1'b0;
    s.idx    = '0;
    s.val    = '0;
    s.frame  = f;
    s.typed  = typed;
    s.want   = want;
    return s;
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    step_row_t s;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    s.frame  = '0;
    s.typed  = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  // drive one frame and wait for its transfer
  task automatic send_frame(feedback_frame_t f, bit typed = 1'b0, result_t want = '0);
    result_t p;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {pos_high, pos_low, vel_high, vel_low, cur_high, cur_low, temp_byte} <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = track_frame(f);
    awaited_results.push_back(typed ? want : p);
  endtask

  // stop sending and wait until every result is back
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CALIBRATED:  calib_on = val[0];
      REG_TORQUE_GAIN: gain_q16 = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // output back-pressure
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 16);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no frame awaiting it");
        mismatches++;
      end else begin
        head_result = awaited_results.pop_front();
        check_field("angle", head_result.frame.angle, angle);
        check_field("speed_rpm", $signed(head_result.frame.speed_rpm), speed_rpm);
        check_field("current_lsb", $signed(head_result.frame.current_lsb), current_lsb);
        check_field("temperature", head_result.frame.temperature, temperature);
        check_field("turns", $signed(head_result.frame.turns), turns);
        check_field("total_counts", $signed(head_result.total_counts), total_counts);
        check_field("prev_total_counts", $signed(head_result.prev_total_counts),
                    prev_total_counts);
        check_field("torque_q16", $signed(head_result.torque_q16), torque_q16);
      end
    end
  end

  // stimulus
  initial begin
    feedback_frame_t f;
    logic [15:0]     enc_pos;
    logic [31:0]     gain;
    int              drift;
    int              step;
    int              mode;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // gain of one LSB, tracking zero, writes to unused indexes dropped
    directed.push_back(cfg_row(REG_TORQUE_GAIN, 32'd1));
    directed.push_back(cfg_row(REG_CALIBRATED, 32'd0));
    directed.push_back(cfg_row(REG_FIRST_UNUSED, '1));
    directed.push_back(cfg_row(REG_LAST_UNUSED, '1));
    // first frame after reset, far from zero: one turn back
    directed.push_back(frame_row(56'hFFFF_7FFF_8000_FF, 1'b1,
      '{frame: '{angle: 16'hFFFF, speed_rpm: 16'sh7FFF, current_lsb: 16'sh8000,
                 temperature: 8'hFF, turns: -32'sd1},
        total_counts: 48'sd57344, prev_total_counts: 48'sd0,
        torque_q16: -48'sd32768}));
    directed.push_back(frame_row(56'h0000_8000_7FFF_00, 1'b1,
      '{frame: '{angle: 16'h0000, speed_rpm: 16'sh8000, current_lsb: 16'sh7FFF,
                 temperature: 8'h00, turns: 32'sd0},
        total_counts: -48'sd57344, prev_total_counts: 48'sd57344,
        torque_q16: 48'sd32767}));
    // threshold edges in both directions
    directed.push_back(frame_row(56'h1000_0001_FFFF_01));
    directed.push_back(frame_row(56'h2001_FFFE_0002_7F));
    directed.push_back(frame_row(56'h1001_0100_00FF_80));
    directed.push_back(frame_row(56'h0000_0080_FF00_40));
    directed.push_back(frame_row(56'h0001_1234_ABCD_12));
    // held zero, largest gain
    directed.push_back(cfg_row(REG_CALIBRATED, 32'd1));
    directed.push_back(cfg_row(REG_TORQUE_GAIN, GAIN_MAX));
    directed.push_back(frame_row(56'hFFFF_0000_8000_FF));
    directed.push_back(frame_row(56'h0000_FFFF_7FFF_00));
    directed.push_back(frame_row(56'hFFFF_5555_AAAA_55));
    directed.push_back(frame_row(56'h8000_AAAA_5555_AA));
    directed.push_back(frame_row(56'h8000_0000_0001_01));
    // tracking again, unity Q16 gain, then zero gain
    directed.push_back(cfg_row(REG_CALIBRATED, 32'd0));
    directed.push_back(cfg_row(REG_TORQUE_GAIN, GAIN_UNITY));
    directed.push_back(frame_row(56'h1234_4321_8001_33));
    directed.push_back(frame_row(56'hFEDC_7FFE_7FFE_CC));
    directed.push_back(cfg_row(REG_TORQUE_GAIN, 32'd0));
    directed.push_back(frame_row(56'h0000_8001_8000_00));
    directed.push_back(frame_row(56'h7FFF_0001_0001_FE));

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        cfg_write(directed[i].idx, directed[i].val);
      end else begin
        send_frame(directed[i].frame, directed[i].typed, directed[i].want);
      end
    end
    enc_pos = 16'h7FFF;

    // random phases: fresh registers and a motion profile per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      cfg_write(REG_CALIBRATED, $urandom());
      case ($urandom_range(3))
        0:       gain = '0;
        1:       gain = GAIN_MAX;
        default: gain = $urandom();
      endcase
      cfg_write(REG_TORQUE_GAIN, gain);
      if ($urandom_range(2) == 0)
        cfg_write(CFG_INDEX_W'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
                  $urandom());
      drift  = int'($urandom_range(14000)) - 7000;
      steady = (ph == STEADY_PHS);
      for (int k = 0; k < PHASE_LEN; k++) begin
        mode = $urandom_range(99);
        if (mode < 55) begin
          // steady rotation with jitter
          step    = drift + int'($urandom_range(2000)) - 1000;
          enc_pos = enc_pos + 16'(step);
        end else if (mode < 70) begin
          // right on the wrap threshold or just past it
          step    = WRAP + int'($urandom_range(1));
          enc_pos = ($urandom_range(1) != 0) ? enc_pos + 16'(step) : enc_pos - 16'(step);
        end else if (mode < 80) begin
          // standstill
        end else begin
          enc_pos = 16'($urandom());
        end
        f = {enc_pos, $urandom(), 8'($urandom())};
        send_frame(f);
      end
      steady = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
